// File: rtl/rmr_pkg.sv
// Shared constants and types for the rotation matrix renormaliser.
`default_nettype none

package rmr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned OW            = 16;  // element width at the ports
  localparam int unsigned VW            = 33;  // signed element into a normaliser
  localparam int unsigned MW            = 30;  // normalised magnitude width
  localparam int unsigned NORM_TOP      = 29;  // leading one sits here after shifting
  localparam int unsigned SSW           = 62;  // sum of three squares
  localparam int unsigned RW            = 31;  // integer square root width

  // side data that rides along the normaliser pipeline
  typedef struct packed {
    logic [2:0][MW-1:0] m;
    logic [2:0]         neg;
    logic               zero;
  } side_t;

  // cycles from a normaliser's valid_i input to its output register
  function automatic int unsigned unit_lat(input int unsigned frac);
    return frac + 39;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rmr_unit3.sv
// Pipelined scaling of a signed 3-vector to unit length.
`default_nettype none

module rmr_unit3 #(
  parameter int unsigned FRAC_BITS = rmr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [2:0][rmr_pkg::VW-1:0]       vec_i,
  output logic                              valid_o,
  output logic [2:0][rmr_pkg::OW-1:0]       unit_o,
  output logic                              zero_o
);

  localparam int unsigned VW  = rmr_pkg::VW;
  localparam int unsigned MW  = rmr_pkg::MW;
  localparam int unsigned OW  = rmr_pkg::OW;
  localparam int unsigned SSW = rmr_pkg::SSW;
  localparam int unsigned RW  = rmr_pkg::RW;
  localparam int unsigned PBW = $clog2(VW);
  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned DW  = MW + FRAC_BITS + 2;
  localparam int unsigned SW  = (QW > OW + 1) ? QW : OW + 1;
  localparam logic [SW-1:0] POS_LIM = SW'(2 ** (OW - 1) - 1);
  localparam logic [SW-1:0] NEG_LIM = SW'(2 ** (OW - 1));

  // stage 0: magnitudes and largest
  logic [2:0][VW-1:0] mag_d;
  logic [2:0]         neg_d;
  logic [VW-1:0]      mx_d;
  logic               s0_valid_q;
  logic [2:0][VW-1:0] s0_mag_q;
  logic [2:0]         s0_neg_q;
  logic [VW-1:0]      s0_mx_q;

  always_comb begin
    mx_d = '0;
    for (int k = 0; k < 3; k++) begin
      neg_d[k] = vec_i[k][VW-1];
      mag_d[k] = neg_d[k] ? (~vec_i[k] + VW'(1)) : vec_i[k];
      if (mag_d[k] > mx_d) begin
        mx_d = mag_d[k];
      end
    end
  end

  // stage 1: leading one of the largest
  logic [PBW-1:0]     msb_d;
  logic               s1_valid_q;
  logic [2:0][VW-1:0] s1_mag_q;
  logic [2:0]         s1_neg_q;
  logic [PBW-1:0]     s1_msb_q;
  logic               s1_zero_q;

  always_comb begin
    msb_d = '0;
    for (int i = 0; i < VW; i++) begin
      if (s0_mx_q[i]) begin
        msb_d = PBW'(i);
      end
    end
  end

  // stage 2: common shift, right shift truncates
  rmr_pkg::side_t     s2_side_d;
  logic [VW-1:0]      sh_d [3];
  logic               s2_valid_q;
  rmr_pkg::side_t     s2_side_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s1_msb_q >= PBW'(rmr_pkg::NORM_TOP)) begin
        sh_d[k] = s1_mag_q[k] >> (s1_msb_q - PBW'(rmr_pkg::NORM_TOP));
      end else begin
        sh_d[k] = s1_mag_q[k] << (PBW'(rmr_pkg::NORM_TOP) - s1_msb_q);
      end
      s2_side_d.m[k] = sh_d[k][MW-1:0];
    end
    s2_side_d.neg  = s1_neg_q;
    s2_side_d.zero = s1_zero_q;
  end

  // stage 3: squares
  logic [2*MW-1:0]    sq_d [3];
  logic               s3_valid_q;
  rmr_pkg::side_t     s3_side_q;
  logic [2*MW-1:0]    s3_sq_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_d[k] = s2_side_q.m[k] * s2_side_q.m[k];
    end
  end

  // square root pipeline, one root bit per stage; index 0 holds the sum
  logic               rt_valid_q [0:RW];
  rmr_pkg::side_t     rt_side_q  [0:RW];
  logic [SSW-1:0]     rt_rem_q   [0:RW];
  logic [RW-1:0]      rt_root_q  [0:RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q    <= 1'b0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      rt_valid_q[0] <= 1'b0;
    end else begin
      s0_valid_q    <= valid_i;
      s1_valid_q    <= s0_valid_q;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      rt_valid_q[0] <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_mag_q     <= mag_d;
    s0_neg_q     <= neg_d;
    s0_mx_q      <= mx_d;
    s1_mag_q     <= s0_mag_q;
    s1_neg_q     <= s0_neg_q;
    s1_msb_q     <= msb_d;
    s1_zero_q    <= (s0_mx_q == '0);
    s2_side_q    <= s2_side_d;
    s3_side_q    <= s2_side_q;
    s3_sq_q      <= sq_d;
    rt_side_q[0] <= s3_side_q;
    rt_rem_q[0]  <= SSW'(s3_sq_q[0]) + SSW'(s3_sq_q[1]) + SSW'(s3_sq_q[2]);
    rt_root_q[0] <= '0;
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int unsigned BI = RW - 1 - k;
    logic [SSW-1:0] trial;
    logic           ge;

    // (root + 2^BI)^2 - root^2
    always_comb begin
      trial = (SSW'(rt_root_q[k]) << (BI + 1)) | (SSW'(1) << (2 * BI));
      ge    = rt_rem_q[k] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_valid_q[k+1] <= 1'b0;
      end else begin
        rt_valid_q[k+1] <= rt_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rt_side_q[k+1] <= rt_side_q[k];
      rt_rem_q[k+1]  <= ge ? (rt_rem_q[k] - trial) : rt_rem_q[k];
      rt_root_q[k+1] <= ge ? (rt_root_q[k] | (RW'(1) << BI)) : rt_root_q[k];
    end
  end

  // division pipeline, one quotient bit per stage; index 0 holds the rounded numerator
  logic               dv_valid_q [0:QW];
  logic [2:0]         dv_neg_q   [0:QW];
  logic               dv_zero_q  [0:QW];
  logic [RW-1:0]      dv_div_q   [0:QW];
  logic [2:0][DW-1:0] dv_rem_q   [0:QW];
  logic [2:0][QW-1:0] dv_quo_q   [0:QW];
  logic [2:0][DW-1:0] num_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_d[k] = (DW'(rt_side_q[RW].m[k]) << FRAC_BITS) + DW'(rt_root_q[RW] >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else begin
      dv_valid_q[0] <= rt_valid_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_neg_q[0]  <= rt_side_q[RW].neg;
    dv_zero_q[0] <= rt_side_q[RW].zero;
    dv_div_q[0]  <= rt_root_q[RW];
    dv_rem_q[0]  <= num_d;
    dv_quo_q[0]  <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int unsigned BJ = QW - 1 - k;
    logic [DW-1:0]      dsh;
    logic [2:0][DW-1:0] rem_d;
    logic [2:0][QW-1:0] quo_d;

    always_comb begin
      dsh = DW'(dv_div_q[k]) << BJ;
      for (int l = 0; l < 3; l++) begin
        if (dv_rem_q[k][l] >= dsh) begin
          rem_d[l] = dv_rem_q[k][l] - dsh;
          quo_d[l] = dv_quo_q[k][l] | (QW'(1) << BJ);
        end else begin
          rem_d[l] = dv_rem_q[k][l];
          quo_d[l] = dv_quo_q[k][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[k+1] <= 1'b0;
      end else begin
        dv_valid_q[k+1] <= dv_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_neg_q[k+1]  <= dv_neg_q[k];
      dv_zero_q[k+1] <= dv_zero_q[k];
      dv_div_q[k+1]  <= dv_div_q[k];
      dv_rem_q[k+1]  <= rem_d;
      dv_quo_q[k+1]  <= quo_d;
    end
  end

  // sign and saturate
  logic [2:0][OW-1:0] unit_d;
  logic [SW-1:0]      qx [3];
  logic               valid_q;
  logic [2:0][OW-1:0] unit_q;
  logic               zero_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qx[k] = SW'(dv_quo_q[QW][k]);
      if (dv_zero_q[QW]) begin
        unit_d[k] = '0;
      end else if (dv_neg_q[QW][k]) begin
        unit_d[k] = (qx[k] > NEG_LIM) ? NEG_LIM[OW-1:0] : (~qx[k][OW-1:0] + OW'(1));
      end else begin
        unit_d[k] = (qx[k] > POS_LIM) ? POS_LIM[OW-1:0] : qx[k][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_valid_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    zero_q <= dv_zero_q[QW];
  end

  assign valid_o = valid_q;
  assign unit_o  = unit_q;
  assign zero_o  = zero_q;

endmodule

`default_nettype wire

// File: rtl/rotation_matrix_renormalize.sv
// Top level of the direction-cosine matrix renormaliser.
//
// Usage: drive rows A, B and C of a matrix (signed, FRAC_BITS fraction bits)
// with start_i high; a word is taken at every rising edge where start_i is
// high and busy_o is low. busy_o is never raised, so a new matrix can enter
// in every cycle and one renormalised matrix leaves per cycle.
// Row C is not used: it is rebuilt as the cross product of the new A and B.
// Each result is shown for exactly one cycle with valid_o high. The receiver
// cannot hold results off and nothing here waits for it.
// The latency comes from two normalisers in series, each with a square root
// pipeline (one root bit per stage) and a restoring divider (one quotient bit
// per stage); the orthogonality correction ahead of them takes four stages.
// fault_o is high when a corrected row or the cross product had zero length;
// that row is then output as zeros.
// Reset empties the pipeline: no result is shown for words taken before it.
`default_nettype none

module rotation_matrix_renormalize #(
  parameter int unsigned FRAC_BITS = rmr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] row_a_x_i,
  input  logic signed [15:0] row_a_y_i,
  input  logic signed [15:0] row_a_z_i,
  input  logic signed [15:0] row_b_x_i,
  input  logic signed [15:0] row_b_y_i,
  input  logic signed [15:0] row_b_z_i,
  input  logic signed [15:0] row_c_x_i,
  input  logic signed [15:0] row_c_y_i,
  input  logic signed [15:0] row_c_z_i,
  output logic               valid_o,
  output logic signed [15:0] new_a_x_o,
  output logic signed [15:0] new_a_y_o,
  output logic signed [15:0] new_a_z_o,
  output logic signed [15:0] new_b_x_o,
  output logic signed [15:0] new_b_y_o,
  output logic signed [15:0] new_b_z_o,
  output logic signed [15:0] new_c_x_o,
  output logic signed [15:0] new_c_y_o,
  output logic signed [15:0] new_c_z_o,
  output logic               fault_o
);

  localparam int unsigned VW  = rmr_pkg::VW;
  localparam int unsigned OW  = rmr_pkg::OW;
  localparam int unsigned LAT = rmr_pkg::unit_lat(FRAC_BITS);
  localparam int unsigned PW  = (2 * FRAC_BITS + 3 > 50) ? 2 * FRAC_BITS + 3 : 50;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  logic signed [15:0] a_in [3];
  logic signed [15:0] b_in [3];
  assign a_in[0] = row_a_x_i;
  assign a_in[1] = row_a_y_i;
  assign a_in[2] = row_a_z_i;
  assign b_in[0] = row_b_x_i;
  assign b_in[1] = row_b_y_i;
  assign b_in[2] = row_b_z_i;

  // correction stages
  logic               v1_q, v2_q, v3_q, v4_q;
  logic signed [15:0] a1_q [3];
  logic signed [15:0] b1_q [3];
  logic signed [31:0] ab1_q [3];
  logic signed [15:0] a2_q [3];
  logic signed [15:0] b2_q [3];
  logic signed [33:0] e2_q;
  logic signed [15:0] a3_q [3];
  logic signed [15:0] b3_q [3];
  logic signed [49:0] eb3_q [3];
  logic signed [49:0] ea3_q [3];
  logic [2:0][VW-1:0] ca4_q;
  logic [2:0][VW-1:0] cb4_q;
  logic [2:0][VW-1:0] ca_d;
  logic [2:0][VW-1:0] cb_d;

  // A - round(e*B/2) and B - round(e*A/2), round half up
  always_comb begin
    logic signed [PW-1:0] xa, xb;
    logic signed [VW-1:0] ra, rb;
    for (int k = 0; k < 3; k++) begin
      xa = (PW'(eb3_q[k]) + (PW'(1) << (2 * FRAC_BITS))) >>> (2 * FRAC_BITS + 1);
      xb = (PW'(ea3_q[k]) + (PW'(1) << (2 * FRAC_BITS))) >>> (2 * FRAC_BITS + 1);
      ra = VW'(xa);
      rb = VW'(xb);
      ca_d[k] = VW'(a3_q[k]) - ra;
      cb_d[k] = VW'(b3_q[k]) - rb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      a1_q[k]  <= a_in[k];
      b1_q[k]  <= b_in[k];
      ab1_q[k] <= a_in[k] * b_in[k];
      a2_q[k]  <= a1_q[k];
      b2_q[k]  <= b1_q[k];
      a3_q[k]  <= a2_q[k];
      b3_q[k]  <= b2_q[k];
      eb3_q[k] <= e2_q * b2_q[k];
      ea3_q[k] <= e2_q * a2_q[k];
    end
    e2_q  <= 34'(ab1_q[0]) + 34'(ab1_q[1]) + 34'(ab1_q[2]);
    ca4_q <= ca_d;
    cb4_q <= cb_d;
  end

  logic               na_valid, nb_valid, nc_valid;
  logic [2:0][OW-1:0] na, nb, nc;
  logic               za, zb, zc;

  rmr_unit3 #(.FRAC_BITS(FRAC_BITS)) u_unit_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .vec_i   (ca4_q),
    .valid_o (na_valid),
    .unit_o  (na),
    .zero_o  (za)
  );

  rmr_unit3 #(.FRAC_BITS(FRAC_BITS)) u_unit_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .vec_i   (cb4_q),
    .valid_o (nb_valid),
    .unit_o  (nb),
    .zero_o  (zb)
  );

  // cross product of the new rows
  logic               x1_valid_q, x2_valid_q;
  logic signed [31:0] xp1_q [6];
  logic [2:0][VW-1:0] cr2_q;
  logic [2:0][OW-1:0] dna_q [0:LAT+1];
  logic [2:0][OW-1:0] dnb_q [0:LAT+1];
  logic               dfl_q [0:LAT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_valid_q <= 1'b0;
      x2_valid_q <= 1'b0;
    end else begin
      x1_valid_q <= na_valid && nb_valid;
      x2_valid_q <= x1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xp1_q[0] <= $signed(na[1]) * $signed(nb[2]);
    xp1_q[1] <= $signed(na[2]) * $signed(nb[1]);
    xp1_q[2] <= $signed(na[2]) * $signed(nb[0]);
    xp1_q[3] <= $signed(na[0]) * $signed(nb[2]);
    xp1_q[4] <= $signed(na[0]) * $signed(nb[1]);
    xp1_q[5] <= $signed(na[1]) * $signed(nb[0]);
    cr2_q[0] <= VW'(xp1_q[0]) - VW'(xp1_q[1]);
    cr2_q[1] <= VW'(xp1_q[2]) - VW'(xp1_q[3]);
    cr2_q[2] <= VW'(xp1_q[4]) - VW'(xp1_q[5]);
    dna_q[0] <= na;
    dnb_q[0] <= nb;
    dfl_q[0] <= za || zb;
  end

  // rows A and B wait alongside the third normaliser
  for (genvar i = 0; i <= LAT; i++) begin : g_delay
    always_ff @(posedge clk_i) begin
      dna_q[i+1] <= dna_q[i];
      dnb_q[i+1] <= dnb_q[i];
      dfl_q[i+1] <= dfl_q[i];
    end
  end

  rmr_unit3 #(.FRAC_BITS(FRAC_BITS)) u_unit_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x2_valid_q),
    .vec_i   (cr2_q),
    .valid_o (nc_valid),
    .unit_o  (nc),
    .zero_o  (zc)
  );

  // output word
  logic               out_valid_q;
  logic [2:0][OW-1:0] out_a_q, out_b_q, out_c_q;
  logic               out_fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= nc_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_a_q     <= dna_q[LAT+1];
    out_b_q     <= dnb_q[LAT+1];
    out_c_q     <= nc;
    out_fault_q <= dfl_q[LAT+1] || zc;
  end

  assign valid_o   = out_valid_q;
  assign new_a_x_o = out_a_q[0];
  assign new_a_y_o = out_a_q[1];
  assign new_a_z_o = out_a_q[2];
  assign new_b_x_o = out_b_q[0];
  assign new_b_y_o = out_b_q[1];
  assign new_b_z_o = out_b_q[2];
  assign new_c_x_o = out_c_q[0];
  assign new_c_y_o = out_c_q[1];
  assign new_c_z_o = out_c_q[2];
  assign fault_o   = out_fault_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the direction-cosine matrix renormaliser.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB      = rmr_pkg::FRAC_BITS_DEF;
  localparam int          LAT     = 2 * FB + 84;
  localparam int          WDOG    = 4000;
  localparam int          N_RAND  = 850;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic               fault;
  } renorm_t;

  logic clk, rst_n, start, busy, valid_o, fault_o;
  logic signed [15:0] ra_x, ra_y, ra_z, rb_x, rb_y, rb_z, rc_x, rc_y, rc_z;
  logic signed [15:0] na_x, na_y, na_z, nb_x, nb_y, nb_z, nc_x, nc_y, nc_z;

  matrix_t pending_q[$];
  renorm_t expected_q[$];
  int      n_errors, n_words_in, n_words_out, n_faults, idle_cycles;
  int      burst_left, gap_left;

  rotation_matrix_renormalize DUT (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .row_a_x_i(ra_x), .row_a_y_i(ra_y), .row_a_z_i(ra_z),
    .row_b_x_i(rb_x), .row_b_y_i(rb_y), .row_b_z_i(rb_z),
    .row_c_x_i(rc_x), .row_c_y_i(rc_y), .row_c_z_i(rc_z),
    .valid_o(valid_o),
    .new_a_x_o(na_x), .new_a_y_o(na_y), .new_a_z_o(na_z),
    .new_b_x_o(nb_x), .new_b_y_o(nb_y), .new_b_z_o(nb_z),
    .new_c_x_o(nc_x), .new_c_y_o(nc_y), .new_c_z_o(nc_z),
    .fault_o(fault_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor((v + 2^(s-1)) / 2^s); arithmetic shift gives the floor directly
  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // scale to unit length; returns 0 for a zero vector
  function automatic bit unit_vector(input longint v[3], output longint o[3]);
    logic [63:0] m[3], mx, n2, r, q;
    longint s;
    mx = 0;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 0;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) n2 = n2 + m[i] * m[i];
    r = floor_sqrt(n2);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (r >> 1)) / r;
      s = (v[i] < 0) ? -longint'(q) : longint'(q);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      o[i] = s;
    end
    return 1;
  endfunction

  function automatic renorm_t renormalise(matrix_t mt);
    longint a[3], b[3], ca[3], cb[3], ua[3], ub[3], cr[3], uc[3], e;
    bit ok;
    renorm_t r;
    a = '{mt.ax, mt.ay, mt.az};
    b = '{mt.bx, mt.by, mt.bz};
    e = 0;
    for (int i = 0; i < 3; i++) e += a[i] * b[i];
    for (int i = 0; i < 3; i++) begin
      ca[i] = a[i] - round_half_up(e * b[i], 2 * FB + 1);
      cb[i] = b[i] - round_half_up(e * a[i], 2 * FB + 1);
    end
    ok = unit_vector(ca, ua);
    ok = unit_vector(cb, ub) && ok;
    cr[0] = ua[1] * ub[2] - ua[2] * ub[1];
    cr[1] = ua[2] * ub[0] - ua[0] * ub[2];
    cr[2] = ua[0] * ub[1] - ua[1] * ub[0];
    ok = unit_vector(cr, uc) && ok;
    r.ax = 16'(ua[0]); r.ay = 16'(ua[1]); r.az = 16'(ua[2]);
    r.bx = 16'(ub[0]); r.by = 16'(ub[1]); r.bz = 16'(ub[2]);
    r.cx = 16'(uc[0]); r.cy = 16'(uc[1]); r.cz = 16'(uc[2]);
    r.fault = !ok;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'(int'($urandom_range(0, 8)) - 4);
      3, 4, 5: return 16'(int'($urandom_range(0, 32768)) - 16384);  // near unit scale
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t mt;
    mt = '{ax: rand_elem(), ay: rand_elem(), az: rand_elem(),
           bx: rand_elem(), by: rand_elem(), bz: rand_elem(),
           cx: 16'($urandom), cy: 16'($urandom), cz: 16'($urandom)};
    case ($urandom_range(0, 19))
      0: {mt.ax, mt.ay, mt.az} = '0;                // zero A
      1: {mt.bx, mt.by, mt.bz} = {mt.ax, mt.ay, mt.az}; // parallel rows
      2: {mt.bx, mt.by, mt.bz} = {-mt.ax, -mt.ay, -mt.az};
      default: ;
    endcase
    return mt;
  endfunction

  // directed words and random fill
  initial begin
    localparam logic signed [15:0] ONE = 16'sd16384;
    localparam logic signed [15:0] MX = 16'sh7fff, MN = 16'sh8000;
    pending_q.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});         // identity
    pending_q.push_back('{0, 0, 0, 0, ONE, 0, 0, 0, 0});             // zero A
    pending_q.push_back('{ONE, 0, 0, 0, 0, 0, 0, 0, 0});             // zero B
    pending_q.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});               // all zero
    pending_q.push_back('{ONE, ONE, 0, ONE, ONE, 0, 1, 2, 3});       // parallel
    pending_q.push_back('{MX, MX, MX, MX, MX, MX, MX, MX, MX});
    pending_q.push_back('{MN, MN, MN, MN, MN, MN, MN, MN, MN});
    pending_q.push_back('{MX, MN, MX, MN, MX, MN, MN, MX, MN});
    pending_q.push_back('{MN, 0, 0, 0, MN, 0, -1, -1, -1});
    pending_q.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 0});               // tiny rows
    pending_q.push_back('{-1, -1, -1, 1, -1, 0, 0, 0, 0});
    pending_q.push_back('{ONE, 100, -100, -200, ONE, 50, 0, 0, 0});  // near-orthogonal
    pending_q.push_back('{16'sd11585, 16'sd11585, 0, -16'sd11585, 16'sd11585, 0, 0, 0, 0});
    pending_q.push_back('{ONE, 0, 0, ONE, 0, 0, 0, 0, 0});           // zero cross
    for (int i = 0; i < N_RAND; i++) pending_q.push_back(rand_matrix());
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: bursts and gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start <= 1'b0;
      {ra_x, ra_y, ra_z, rb_x, rb_y, rb_z, rc_x, rc_y, rc_z} <= '0;
      burst_left <= 0;
      gap_left <= 0;
      n_words_in <= 0;
    end else begin
      matrix_t mt;
      bit accepted;
      accepted = start && !busy;
      if (accepted) begin
        expected_q.push_back(renormalise(pending_q.pop_front()));
        n_words_in <= n_words_in + 1;
      end
      if (start && !accepted) begin
        // hold the word until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        mt = pending_q[0];
        start <= 1'b1;
        {ra_x, ra_y, ra_z, rb_x, rb_y, rb_z, rc_x, rc_y, rc_z} <= mt;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic signed [15:0] exp_v,
                             logic signed [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    renorm_t e;
    if (rst_n && valid_o === 1'b1) begin
      n_words_out++;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.fault) n_faults++;
        check_field("new_a_x", e.ax, na_x);
        check_field("new_a_y", e.ay, na_y);
        check_field("new_a_z", e.az, na_z);
        check_field("new_b_x", e.bx, nb_x);
        check_field("new_b_y", e.by, nb_y);
        check_field("new_b_z", e.bz, nb_z);
        check_field("new_c_x", e.cx, nc_x);
        check_field("new_c_y", e.cy, nc_y);
        check_field("new_c_z", e.cz, nc_z);
        if (e.fault !== fault_o) begin
          $error("fault: expected %0d, got %0d", e.fault, fault_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || valid_o === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("timeout with %0d words outstanding", expected_q.size());
      $display("rotation_matrix_renormalize verification failed");
      $finish;
    end
  end

  initial begin
    n_errors = 0;
    n_words_out = 0;
    n_faults = 0;
    @(posedge rst_n);
    wait (pending_q.size() == 0 && !start);
    wait (expected_q.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    $display("%0d matrices in, %0d out, %0d with a zero-length row",
             n_words_in, n_words_out, n_faults);
    if (n_errors == 0) $display("rotation_matrix_renormalize verification clean");
    else $display("rotation_matrix_renormalize verification failed");
    $finish;
  end

endmodule

`default_nettype wire
